// ===== design/name_table_insert_delete_search_macros.svh =====
// assertion macros shared by the name table modules
`ifndef NAME_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH
`define NAME_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH

// property that must hold at every clock edge out of reset
`define NTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define NTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nti_pkg.sv =====
package nti_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int NAME_BYTES  = 64;

    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int BYTE_W      = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int LEN_W       = $clog2(NAME_BYTES + 1);
    localparam int STORE_DEPTH = MAX_ENTRIES * NAME_BYTES;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NBUF_DEPTH  = 2 * NAME_BYTES;
    localparam int NBUF_AW     = $clog2(NBUF_DEPTH);

    // request codes
    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_FOUND     = 3'd6,
        ST_TOO_LONG  = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] name_char;
        logic       last_char;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] match_index;
        logic [7:0] entry_count;
    } result_t;

    // completed name handed from front to back
    typedef struct packed {
        logic [1:0]       req;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             bank;
    } cmd_t;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [IDX_W-1:0] ent,
                                                       input logic [BYTE_W-1:0] pos);
        store_addr = STORE_AW'(STORE_AW'(ent) * STORE_AW'(NAME_BYTES) + STORE_AW'(pos));
    endfunction

    function automatic logic [NBUF_AW-1:0] nbuf_addr(input logic bank,
                                                     input logic [BYTE_W-1:0] pos);
        nbuf_addr = NBUF_AW'(NBUF_AW'(bank) * NBUF_AW'(NAME_BYTES) + NBUF_AW'(pos));
    endfunction

endpackage

// ===== design/nti_ram.sv =====
module nti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/nti_front.sv =====
`include "name_table_insert_delete_search_macros.svh"

module nti_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nti_pkg::item_t               item,
    input  logic                         push,
    output logic                         full,
    output logic                         nbuf_we,
    output logic [nti_pkg::NBUF_AW-1:0]  nbuf_waddr,
    output logic [7:0]                   nbuf_wdata,
    output logic                         cmd_valid,
    output nti_pkg::cmd_t                cmd,
    input  logic                         cmd_done
);
    import nti_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       qcnt_reg, qcnt_next;
    cmd_t             q_reg [2];
    cmd_t             new_cmd;
    logic             acc;
    logic             room;
    logic             push_q;

    // one name bank per queue slot, so full once both hold names
    assign full   = (qcnt_reg == 2'd2);
    assign acc    = push && !full;
    assign room   = (len_reg < LEN_W'(NAME_BYTES));
    assign push_q = acc && item.last_char;

    // character write into the current bank
    assign nbuf_we    = acc && room;
    assign nbuf_waddr = nbuf_addr(bank_reg, len_reg[BYTE_W-1:0]);
    assign nbuf_wdata = item.name_char;

    // command for a completed name
    always_comb
    begin
        new_cmd.req  = item.req_type;
        new_cmd.len  = room ? LEN_W'(len_reg + LEN_W'(1)) : len_reg;
        new_cmd.ovf  = ovf_reg || !room;
        new_cmd.bank = bank_reg;
    end

    assign cmd_valid = (qcnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    // name assembly and queue bookkeeping
    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        qcnt_next = qcnt_reg;
        if (acc)
        begin
            if (item.last_char)
            begin
                len_next  = '0;
                ovf_next  = 1'b0;
                bank_next = !bank_reg;
                wp_next   = !wp_reg;
            end
            else if (room)
            begin
                len_next = LEN_W'(len_reg + LEN_W'(1));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd_done)
        begin
            rp_next = !rp_reg;
        end
        if (push_q && !cmd_done)
        begin
            qcnt_next = qcnt_reg + 2'd1;
        end
        else if (!push_q && cmd_done)
        begin
            qcnt_next = qcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            qcnt_reg <= qcnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            q_reg[wp_reg] <= new_cmd;
        end
    end

    `NTI_ASSERT(a_qcnt_range, qcnt_reg != 2'd3, "command queue count out of range")
    `NTI_ASSERT_NEXT(a_last_clears, push_q, len_reg == '0 && !ovf_reg, "name state not cleared")
    `NTI_ASSERT(a_done_has_cmd, cmd_done |-> cmd_valid, "command retired from empty queue")

endmodule

// ===== design/nti_back.sv =====
`include "name_table_insert_delete_search_macros.svh"

module nti_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  nti_pkg::cmd_t                cmd,
    output logic                         cmd_done,
    output logic [nti_pkg::NBUF_AW-1:0]  nbuf_raddr,
    input  logic [7:0]                   nbuf_rdata,
    output nti_pkg::result_t             result,
    output logic                         empty,
    input  logic                         pop
);
    import nti_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_LEN_RD   = 10'b0000000010,
        S_LEN_CHK  = 10'b0000000100,
        S_BYTE_RD  = 10'b0000001000,
        S_BYTE_CHK = 10'b0000010000,
        S_SHIFT_RD = 10'b0000100000,
        S_SHIFT_WR = 10'b0001000000,
        S_COPY_RD  = 10'b0010000000,
        S_COPY_WR  = 10'b0100000000,
        S_SPARE    = 10'b1000000000
    } state_t;

    state_t            st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  ent_reg, ent_next;
    logic [LEN_W-1:0]  byte_reg, byte_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              fin;
    status_t           fin_status;
    logic [IDX_W-1:0]  fin_idx;
    logic [IDX_W-1:0]  ent_idx;
    logic [IDX_W-1:0]  src_ent;
    logic [BYTE_W-1:0] byte_idx;
    logic              shifting;
    logic              byte_last;
    logic              is_create;
    logic              is_delete;

    logic              st_we;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic [7:0]        st_wdata, st_rdata;
    logic              len_we;
    logic [IDX_W-1:0]  len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_rdata;

    assign ent_idx   = ent_reg[IDX_W-1:0];
    assign src_ent   = IDX_W'(ent_idx + IDX_W'(1));
    assign byte_idx  = byte_reg[BYTE_W-1:0];
    assign shifting  = (st_reg == S_SHIFT_RD) || (st_reg == S_SHIFT_WR);
    assign byte_last = (LEN_W'(byte_reg + LEN_W'(1)) == cmd.len);
    assign is_create = (cmd.req == REQ_CREATE);
    assign is_delete = (cmd.req == REQ_DELETE);

    // read and write addresses follow the walk position
    assign st_raddr   = store_addr(shifting ? src_ent : ent_idx, byte_idx);
    assign len_raddr  = shifting ? src_ent : ent_idx;
    assign nbuf_raddr = nbuf_addr(cmd.bank, byte_idx);
    assign st_waddr   = store_addr(ent_idx, byte_idx);
    assign st_wdata   = shifting ? st_rdata : nbuf_rdata;
    assign len_wdata  = shifting ? len_rdata : cmd.len;

    nti_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    nti_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_lengths (
        .clk   (clk),
        .we    (len_we),
        .waddr (ent_idx),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    // table sequencer
    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        ent_next       = ent_reg;
        byte_next      = byte_reg;
        pos_next       = pos_reg;
        fin            = 1'b0;
        fin_status     = ST_CREATED;
        fin_idx        = '0;
        st_we          = 1'b0;
        len_we         = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    ent_next = '0;
                    if (is_create && cnt_reg == CNT_W'(MAX_ENTRIES))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end
                    else if (!is_create && cnt_reg == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                    end
                    else if (cmd.ovf)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_TOO_LONG;
                    end
                    else
                    begin
                        st_next = S_LEN_RD;
                    end
                end
            end
            S_LEN_RD:
            begin
                if (ent_reg == cnt_reg)
                begin
                    if (is_create)
                    begin
                        byte_next = '0;
                        st_next   = S_COPY_RD;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    st_next = S_LEN_CHK;
                end
            end
            S_LEN_CHK:
            begin
                if (len_rdata == cmd.len)
                begin
                    byte_next = '0;
                    st_next   = S_BYTE_RD;
                end
                else
                begin
                    ent_next = CNT_W'(ent_reg + CNT_W'(1));
                    st_next  = S_LEN_RD;
                end
            end
            S_BYTE_RD:
            begin
                st_next = S_BYTE_CHK;
            end
            S_BYTE_CHK:
            begin
                if (st_rdata != nbuf_rdata)
                begin
                    ent_next = CNT_W'(ent_reg + CNT_W'(1));
                    st_next  = S_LEN_RD;
                end
                else if (!byte_last)
                begin
                    byte_next = LEN_W'(byte_reg + LEN_W'(1));
                    st_next   = S_BYTE_RD;
                end
                else if (is_create)
                begin
                    fin        = 1'b1;
                    fin_status = ST_EXISTS;
                end
                else if (!is_delete)
                begin
                    fin        = 1'b1;
                    fin_status = ST_FOUND;
                    fin_idx    = ent_idx;
                end
                else if (CNT_W'(ent_reg + CNT_W'(1)) == cnt_reg)
                begin
                    // last entry goes, nothing to move
                    cnt_next   = CNT_W'(cnt_reg - CNT_W'(1));
                    fin        = 1'b1;
                    fin_status = ST_DELETED;
                    fin_idx    = ent_idx;
                end
                else
                begin
                    pos_next  = ent_idx;
                    byte_next = '0;
                    st_next   = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                st_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // move one byte of the next entry down one place
                st_we  = 1'b1;
                len_we = (byte_reg == '0);
                if (byte_reg == LEN_W'(NAME_BYTES - 1))
                begin
                    ent_next  = CNT_W'(ent_reg + CNT_W'(1));
                    byte_next = '0;
                    if (CNT_W'(ent_reg + CNT_W'(2)) == cnt_reg)
                    begin
                        cnt_next   = CNT_W'(cnt_reg - CNT_W'(1));
                        fin        = 1'b1;
                        fin_status = ST_DELETED;
                        fin_idx    = pos_reg;
                    end
                    else
                    begin
                        st_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    byte_next = LEN_W'(byte_reg + LEN_W'(1));
                    st_next   = S_SHIFT_RD;
                end
            end
            S_COPY_RD:
            begin
                st_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                // append the name at the end of the table
                st_we = 1'b1;
                if (byte_last)
                begin
                    len_we     = 1'b1;
                    cnt_next   = CNT_W'(cnt_reg + CNT_W'(1));
                    fin        = 1'b1;
                    fin_status = ST_CREATED;
                    fin_idx    = ent_idx;
                end
                else
                begin
                    byte_next = LEN_W'(byte_reg + LEN_W'(1));
                    st_next   = S_COPY_RD;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            st_next = S_IDLE;
        end
    end

    assign cmd_done = fin;

    // result register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (fin)
        begin
            out_next.status      = fin_status;
            out_next.match_index = 7'(fin_idx);
            out_next.entry_count = 8'(cnt_next);
            out_valid_next       = 1'b1;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt_reg       <= '0;
            ent_reg       <= '0;
            byte_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            ent_reg       <= ent_next;
            byte_reg      <= byte_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `NTI_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_ENTRIES), "entry count above table size")
    `NTI_ASSERT(a_fin_slot_free, fin |-> !out_valid_reg, "result overwritten before pop")
    `NTI_ASSERT_NEXT(a_fin_shows, fin, out_valid_reg, "finished transaction not presented")

endmodule

// ===== design/name_table_insert_delete_search.sv =====
// Name table: keeps up to MAX_ENTRIES unique names of up to NAME_BYTES bytes.
// Characters are taken one per cycle while full is low into one of two name
// banks; a name completed by last_char is queued (two names deep) for the
// table engine, and full rises only while both banks hold queued names. Each
// non-last character gives no result; each last character gives exactly one.
// The engine walks the table with single-port reads of a length memory and a
// byte store, checking each entry's length and then its bytes; a create copies
// the name bytes to the end of the table, and a delete moves each later entry
// down one place. Full, empty and too-long answers need no walk. The engine
// starts a name only while its result register is empty.
module name_table_insert_delete_search (
    input  logic             clk,
    input  logic             rst_n,
    input  nti_pkg::item_t   item,
    input  logic             push,
    output logic             full,
    output nti_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import nti_pkg::*;

    logic               nbuf_we;
    logic [NBUF_AW-1:0] nbuf_waddr;
    logic [NBUF_AW-1:0] nbuf_raddr;
    logic [7:0]         nbuf_wdata;
    logic [7:0]         nbuf_rdata;
    logic               cmd_valid;
    logic               cmd_done;
    cmd_t               cmd;

    // character intake and name queue
    nti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .full       (full),
        .nbuf_we    (nbuf_we),
        .nbuf_waddr (nbuf_waddr),
        .nbuf_wdata (nbuf_wdata),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_done   (cmd_done)
    );

    // two banks of name bytes
    nti_ram #(.WIDTH(8), .DEPTH(NBUF_DEPTH)) u_name_buf (
        .clk   (clk),
        .we    (nbuf_we),
        .waddr (nbuf_waddr),
        .wdata (nbuf_wdata),
        .raddr (nbuf_raddr),
        .rdata (nbuf_rdata)
    );

    // table engine and result register
    nti_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_done   (cmd_done),
        .nbuf_raddr (nbuf_raddr),
        .nbuf_rdata (nbuf_rdata),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ===== verif/name_table_insert_delete_search_tb.sv =====
`timescale 1ns / 1ps

module name_table_insert_delete_search_tb;
    import nti_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int QUIET_TAIL = 100;

    // golden model of the name table plus expected result store
    class name_table_scoreboard;
        logic [NAME_BYTES*8-1:0] names[$];
        int unsigned name_lens[$];
        logic [NAME_BYTES*8-1:0] cur_name;
        int unsigned cur_len;
        bit cur_ovf;
        result_t pending[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned status_seen[8];
        int unsigned peak_count;

        function new();
            cur_name = '0;
            cur_len = 0;
            cur_ovf = 0;
            mismatches = 0;
            checked = 0;
            peak_count = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        task report(input string what, input int got, input int want);
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        // apply one accepted transaction to the model
        function void note(input item_t it);
            result_t r;
            int pos;
            pos = -1;
            if (cur_len < NAME_BYTES) begin
                cur_name[cur_len*8 +: 8] = it.name_char;
                cur_len++;
            end
            else
                cur_ovf = 1;
            if (!it.last_char) return;
            if (!cur_ovf) begin
                for (int i = 0; i < names.size(); i++)
                    if (pos < 0 && name_lens[i] == cur_len && names[i] == cur_name)
                        pos = i;
            end
            r.match_index = '0;
            if (it.req_type == REQ_CREATE) begin
                if (names.size() >= MAX_ENTRIES) r.status = ST_FULL;
                else if (cur_ovf) r.status = ST_TOO_LONG;
                else if (pos >= 0) r.status = ST_EXISTS;
                else begin
                    r.status = ST_CREATED;
                    r.match_index = 7'(names.size());
                    names.push_back(cur_name);
                    name_lens.push_back(cur_len);
                end
            end
            else if (names.size() == 0) r.status = ST_EMPTY;
            else if (cur_ovf) r.status = ST_TOO_LONG;
            else if (pos < 0) r.status = ST_NOT_FOUND;
            else if (it.req_type == REQ_DELETE) begin
                r.status = ST_DELETED;
                r.match_index = 7'(pos);
                names.delete(pos);
                name_lens.delete(pos);
            end
            else begin
                r.status = ST_FOUND;
                r.match_index = 7'(pos);
            end
            r.entry_count = 8'(names.size());
            if (names.size() > peak_count) peak_count = names.size();
            pending.push_back(r);
            cur_name = '0;
            cur_len = 0;
            cur_ovf = 0;
        endfunction

        // compare one accepted result against the oldest expectation
        task check(input result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $display("[%0t] unexpected result status %0d", $realtime, got.status);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.match_index !== want.match_index)
                report("match_index", got.match_index, want.match_index);
            if (got.entry_count !== want.entry_count)
                report("entry_count", got.entry_count, want.entry_count);
        endtask
    endclass

    logic clk;
    logic rst_n;
    item_t item;
    logic push;
    logic full;
    result_t result;
    logic empty;
    logic pop;

    name_table_insert_delete_search u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    name_table_scoreboard sb;
    item_t stim[$];
    logic [7:0] pool[12][$];
    int unsigned sent;
    int unsigned popped;
    int unsigned idle_cycles;
    bit quiet;
    bit stalled_seen;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // queue up one complete name with its request on the last character
    task add_name(input logic [1:0] req, input logic [7:0] nm[$]);
        item_t it;
        for (int i = 0; i < nm.size(); i++) begin
            it.req_type = (i == nm.size() - 1) ? req : 2'($urandom_range(0, 3));
            it.name_char = nm[i];
            it.last_char = (i == nm.size() - 1);
            stim.push_back(it);
        end
    endtask

    task add_random_mix(input int n_items);
        logic [7:0] nm[$];
        int len;
        int sel;
        logic [1:0] req;
        int target;
        target = stim.size() + n_items;
        while (stim.size() < target) begin
            sel = $urandom_range(0, 99);
            nm.delete();
            if (sel < 70)
                nm = pool[$urandom_range(0, 11)];
            else begin
                if (sel < 88) len = $urandom_range(1, 6);
                else if (sel < 94) len = $urandom_range(58, NAME_BYTES);
                else len = $urandom_range(NAME_BYTES + 1, NAME_BYTES + 6);
                for (int i = 0; i < len; i++) nm.push_back(8'($urandom_range(0, 255)));
            end
            sel = $urandom_range(0, 9);
            req = (sel < 4) ? REQ_CREATE : (sel < 7) ? REQ_DELETE :
                  (sel < 9) ? REQ_SEARCH : REQ_SPARE;
            add_name(req, nm);
        end
    endtask

    // stimulus plan
    initial begin
        logic [7:0] nm[$];
        for (int p = 0; p < 12; p++) begin
            int len;
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) pool[p].push_back(8'($urandom_range(0, 255)));
        end
        // directed: empty table, create, duplicate, found, not found, spare code, delete
        nm = '{8'h41};
        add_name(REQ_SEARCH, nm);
        add_name(REQ_DELETE, nm);
        add_name(REQ_CREATE, nm);
        add_name(REQ_CREATE, nm);
        add_name(REQ_SEARCH, nm);
        add_name(REQ_SPARE, nm);
        nm = '{8'h00, 8'hFF};
        add_name(REQ_CREATE, nm);
        add_name(REQ_SEARCH, nm);
        nm = '{8'h41, 8'h00};
        add_name(REQ_SEARCH, nm);
        nm = '{8'hFF, 8'h20, 8'h09};
        add_name(REQ_DELETE, nm);
        nm = '{8'h41};
        add_name(REQ_DELETE, nm);
        nm = '{8'h00, 8'hFF};
        add_name(REQ_SEARCH, nm);
        // random mix
        add_random_mix(320);
        // fill the table with distinct three-byte names, then probe it
        for (int i = 0; i < 140; i++) begin
            nm = '{8'hA5, 8'(i), 8'($urandom_range(0, 255))};
            add_name(REQ_CREATE, nm);
        end
        add_random_mix(100);
        add_random_mix(100);
    end

    // transaction monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full) begin
                sb.note(item);
                sent++;
            end
            if (pop && !empty) begin
                sb.check(result);
                popped++;
            end
            if (push && full) stalled_seen = 1;
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending.size());
                $display("name_table_insert_delete_search verification failed");
                $finish;
            end
        end
    end

    // sender
    initial begin
        int gap;
        sb = new();
        sent = 0;
        popped = 0;
        idle_cycles = 0;
        quiet = 0;
        stalled_seen = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int k = 0; k < stim.size(); k++) begin
            if (k > stim.size() - QUIET_TAIL) quiet = 1;
            if (!quiet && $urandom_range(0, 4) == 0) begin
                push = 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(negedge clk);
            end
            push = 1'b1;
            item = stim[k];
            do @(posedge clk); while (full);
            @(negedge clk);
        end
        push = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("covered %0d transactions in, %0d results, peak table size %0d, stall %0s",
                 sent, sb.checked, sb.peak_count, stalled_seen ? "seen" : "not seen");
        $write("status counts: created %0d exists %0d full %0d deleted %0d notfound %0d",
               sb.status_seen[ST_CREATED], sb.status_seen[ST_EXISTS],
               sb.status_seen[ST_FULL], sb.status_seen[ST_DELETED],
               sb.status_seen[ST_NOT_FOUND]);
        $display(" empty %0d found %0d toolong %0d",
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_FOUND],
                 sb.status_seen[ST_TOO_LONG]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("name_table_insert_delete_search verification clean");
        else
            $display("name_table_insert_delete_search verification failed");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        bit held;
        int gap;
        held = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && popped >= 20) begin
                held = 1;
                pop = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (!quiet && $urandom_range(0, 4) == 0) begin
                pop = 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
        end
    end

endmodule

// ===== files.f =====
+incdir+design
design/nti_pkg.sv
design/nti_ram.sv
design/nti_front.sv
design/nti_back.sv
design/name_table_insert_delete_search.sv
verif/name_table_insert_delete_search_tb.sv
